### sv/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  `ASSERT_CLK(label, clk, rst, !(cond))

`endif

### sv/bzs_pkg.sv
// Shared constants for the cubic Bezier subdivider
package bzs_pkg;

  localparam int NUM_PTS = 7;
  localparam int IDX_W = 3;
  localparam int T_IN_W = 16;
  localparam logic [IDX_W-1:0] FIRST_IDX = 3'd0;
  localparam logic [IDX_W-1:0] LAST_IDX = 3'd6;

endpackage

### sv/cubic_bezier_subdivider_top.sv
// Cubic Bezier de Casteljau subdivider, top level
// Flow: an input word passes the six lerp stages and is loaded into the output sequencer,
//   which then offers the seven points one word per cycle while m_axis_tready is high.
// Throughput: set by the single output channel, which takes a new curve with the last point;
//   the six lerp stages (multiply, shift-add per level) take a word per cycle unless stalled.
// Reset: synchronous rst clears stage valid bits and the output sequencer.
module cubic_bezier_subdivider_top #(
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y, split_t
  input  logic [((8*COORD_WIDTH+bzs_pkg::T_IN_W+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // point_index, out_x, out_y
  output logic [((2*COORD_WIDTH+bzs_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast   // is_last
);

  import bzs_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int TW = T_FRAC_BITS;
  localparam int OUT_W = ((2*CW+IDX_W+7)/8)*8;
  localparam int NSTG = 6;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;
  logic            ser_ready;

  logic [TW-1:0] t_in;
  logic [TW-1:0] t_q [1:4];

  logic signed [CW-1:0] ser_pt [2][NUM_PTS];

  logic [IDX_W-1:0]     o_idx;
  logic signed [CW-1:0] o_x;
  logic signed [CW-1:0] o_y;

  // stall chain: a stage may advance when empty or when the next one advances
  assign en[NSTG+1]     = ser_ready;
  assign s_axis_tready  = en[1];
  assign t_in           = TW'(s_axis_tdata[8*CW +: T_IN_W]);

  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) t_q[1] <= t_in;
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) t_q[k] <= t_q[k-1];
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [CW-1:0] c_in [4];
    logic signed [CW-1:0] st_q [1:NSTG];
    logic signed [CW-1:0] ed_q [1:NSTG];
    logic signed [CW-1:0] p_l1 [3];
    logic signed [CW-1:0] p0_q [3:NSTG];
    logic signed [CW-1:0] p2_q [3:NSTG];
    logic signed [CW-1:0] p01;
    logic signed [CW-1:0] p12;
    logic signed [CW-1:0] p01_q [5:NSTG];
    logic signed [CW-1:0] p12_q [5:NSTG];
    logic signed [CW-1:0] dpt;

    for (genvar k = 0; k < 4; k++) begin : g_unpack
      assign c_in[k] = s_axis_tdata[(2*k+ax)*CW +: CW];
    end

    // level one: edges of the control polygon
    for (genvar k = 0; k < 3; k++) begin : g_l1
      bzs_lerp #(.CW(CW), .TW(TW)) u_lerp (
        .clk   (clk),
        .en_mul(en[1]),
        .en_add(en[2]),
        .a     (c_in[k]),
        .b     (c_in[k+1]),
        .t     (t_in),
        .y     (p_l1[k])
      );
    end

    bzs_lerp #(.CW(CW), .TW(TW)) u_l2a (
      .clk(clk), .en_mul(en[3]), .en_add(en[4]),
      .a(p_l1[0]), .b(p_l1[1]), .t(t_q[2]), .y(p01)
    );

    bzs_lerp #(.CW(CW), .TW(TW)) u_l2b (
      .clk(clk), .en_mul(en[3]), .en_add(en[4]),
      .a(p_l1[1]), .b(p_l1[2]), .t(t_q[2]), .y(p12)
    );

    bzs_lerp #(.CW(CW), .TW(TW)) u_l3 (
      .clk(clk), .en_mul(en[5]), .en_add(en[6]),
      .a(p01), .b(p12), .t(t_q[4]), .y(dpt)
    );

    always_ff @(posedge clk) begin
      if (en[1]) begin
        st_q[1] <= c_in[0];
        ed_q[1] <= c_in[3];
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          st_q[k] <= st_q[k-1];
          ed_q[k] <= ed_q[k-1];
        end
      end
      if (en[3]) begin
        p0_q[3] <= p_l1[0];
        p2_q[3] <= p_l1[2];
      end
      for (int k = 4; k <= NSTG; k++) begin
        if (en[k]) begin
          p0_q[k] <= p0_q[k-1];
          p2_q[k] <= p2_q[k-1];
        end
      end
      if (en[5]) begin
        p01_q[5] <= p01;
        p12_q[5] <= p12;
      end
      if (en[6]) begin
        p01_q[6] <= p01_q[5];
        p12_q[6] <= p12_q[5];
      end
    end

    assign ser_pt[ax][0] = st_q[NSTG];
    assign ser_pt[ax][1] = p0_q[NSTG];
    assign ser_pt[ax][2] = p01_q[NSTG];
    assign ser_pt[ax][3] = dpt;
    assign ser_pt[ax][4] = p12_q[NSTG];
    assign ser_pt[ax][5] = p2_q[NSTG];
    assign ser_pt[ax][6] = ed_q[NSTG];
  end

  bzs_serializer #(.CW(CW)) u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NSTG]),
    .in_ready (ser_ready),
    .in_x     (ser_pt[0]),
    .in_y     (ser_pt[1]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_index(o_idx),
    .out_x    (o_x),
    .out_y    (o_y),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({o_y, o_x, o_idx});

`include "assert_macros.svh"

  `ASSERT_CLK(a_last_on_final, clk, rst, m_axis_tvalid |-> (m_axis_tlast == (o_idx == LAST_IDX)))
  `ASSERT_CLK(a_idx_steps, clk, rst, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (o_idx == $past(o_idx) + 1'b1)))
  `ASSERT_CLK(a_tail_held, clk, rst, (vld[NSTG] && !ser_ready) |=> vld[NSTG])
  `ASSERT_NEVER(a_no_early_take, clk, rst, ser_ready && m_axis_tvalid && !(m_axis_tready && m_axis_tlast))

endmodule

### sv/bzs_lerp.sv
// Two-stage fixed-point lerp: a + ((t * (b - a)) >>> TW)
module bzs_lerp #(
  parameter int CW = 32,
  parameter int TW = 16
) (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_add,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic        [TW-1:0] t,
  output logic signed [CW-1:0] y
);

  localparam int PW = CW + TW + 2;

  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic signed [CW-1:0] a_q;

  assign diff = (CW+1)'(b) - (CW+1)'(a);
  assign prod_next = PW'(diff) * PW'($signed({1'b0, t}));
  assign shifted = prod >>> TW;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= prod_next;
      a_q  <= a;
    end
    if (en_add) begin
      y <= a_q + CW'(shifted);
    end
  end

endmodule

### sv/bzs_serializer.sv
// Holds one subdivided curve and sends its seven points one word at a time
module bzs_serializer #(
  parameter int CW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [CW-1:0]          in_x [bzs_pkg::NUM_PTS],
  input  logic signed [CW-1:0]          in_y [bzs_pkg::NUM_PTS],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bzs_pkg::IDX_W-1:0]     out_index,
  output logic signed [CW-1:0]          out_x,
  output logic signed [CW-1:0]          out_y,
  output logic                          out_last
);

  import bzs_pkg::*;

  logic signed [CW-1:0] buf_x [NUM_PTS];
  logic signed [CW-1:0] buf_y [NUM_PTS];
  logic [IDX_W-1:0]     cnt;
  logic                 busy;
  logic                 load;

  assign out_last  = (cnt == LAST_IDX);
  assign in_ready  = !busy || (out_ready && out_last);
  assign load      = in_valid && in_ready;
  assign out_valid = busy;
  assign out_index = cnt;
  assign out_x     = buf_x[cnt];
  assign out_y     = buf_y[cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= FIRST_IDX;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= FIRST_IDX;
    end else if (busy && out_ready) begin
      if (out_last) begin
        busy <= 1'b0;
        cnt  <= FIRST_IDX;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_x <= in_x;
      buf_y <= in_y;
    end
  end

endmodule

### tb/testbench.sv
// Testbench for cubic_bezier_subdivider_top: de Casteljau split checked against a local predictor
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_W = 32;
  localparam int T_FRAC = 16;
  localparam int S_W = ((8*COORD_W+bzs_pkg::T_IN_W+7)/8)*8;
  localparam int M_W = ((2*COORD_W+bzs_pkg::IDX_W+7)/8)*8;
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // start_x in the lowest bits, split_t on top: same layout as s_axis_tdata
  typedef struct packed {
    logic [bzs_pkg::T_IN_W-1:0] split_t;
    coord_t end_y;
    coord_t end_x;
    coord_t ctrl_b_y;
    coord_t ctrl_b_x;
    coord_t ctrl_a_y;
    coord_t ctrl_a_x;
    coord_t start_y;
    coord_t start_x;
  } curve_t;

  typedef struct packed {
    logic is_last;
    coord_t out_y;
    coord_t out_x;
    logic [bzs_pkg::IDX_W-1:0] point_index;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  point_t expected_points[$];
  int error_count = 0;

  cubic_bezier_subdivider_top #(
    .COORD_WIDTH(COORD_W),
    .T_FRAC_BITS(T_FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // a + floor(t * (b - a) / 2^T_FRAC), exact in 64 bits
  function automatic coord_t lerp_fixed(coord_t a, coord_t b, logic [T_FRAC-1:0] t);
    longint diff;
    longint prod;
    longint sum;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'(t);
    sum = longint'(a) + (prod >>> T_FRAC);
    return sum[COORD_W-1:0];
  endfunction

  function automatic void predict_split(curve_t c);
    logic [T_FRAC-1:0] t;
    coord_t xs[bzs_pkg::NUM_PTS];
    coord_t ys[bzs_pkg::NUM_PTS];
    coord_t p0x, p0y, p1x, p1y, p2x, p2y;
    point_t p;
    t = c.split_t[T_FRAC-1:0];
    p0x = lerp_fixed(c.start_x, c.ctrl_a_x, t);
    p0y = lerp_fixed(c.start_y, c.ctrl_a_y, t);
    p1x = lerp_fixed(c.ctrl_a_x, c.ctrl_b_x, t);
    p1y = lerp_fixed(c.ctrl_a_y, c.ctrl_b_y, t);
    p2x = lerp_fixed(c.ctrl_b_x, c.end_x, t);
    p2y = lerp_fixed(c.ctrl_b_y, c.end_y, t);
    xs[0] = c.start_x;  ys[0] = c.start_y;
    xs[1] = p0x;        ys[1] = p0y;
    xs[2] = lerp_fixed(p0x, p1x, t);
    ys[2] = lerp_fixed(p0y, p1y, t);
    xs[4] = lerp_fixed(p1x, p2x, t);
    ys[4] = lerp_fixed(p1y, p2y, t);
    xs[3] = lerp_fixed(xs[2], xs[4], t);
    ys[3] = lerp_fixed(ys[2], ys[4], t);
    xs[5] = p2x;        ys[5] = p2y;
    xs[6] = c.end_x;    ys[6] = c.end_y;
    for (int k = 0; k < bzs_pkg::NUM_PTS; k++) begin
      p.point_index = bzs_pkg::IDX_W'(k);
      p.out_x = xs[k];
      p.out_y = ys[k];
      p.is_last = (p.point_index == bzs_pkg::LAST_IDX);
      expected_points.push_back(p);
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      2, 3: return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [bzs_pkg::T_IN_W-1:0] rand_split();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return bzs_pkg::T_IN_W'($urandom);
    endcase
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    c.start_x = rand_coord();
    c.start_y = rand_coord();
    c.ctrl_a_x = rand_coord();
    c.ctrl_a_y = rand_coord();
    c.ctrl_b_x = rand_coord();
    c.ctrl_b_y = rand_coord();
    c.end_x = rand_coord();
    c.end_y = rand_coord();
    c.split_t = rand_split();
    return c;
  endfunction

  // leaves tvalid high after the handshake; the next call lowers it for a gap or keeps it, else the caller lowers it
  task automatic send_curve(curve_t c, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= S_W'(c);
    do @(posedge clk); while (!s_axis_tready);
    predict_split(c);
  endtask

  always @(posedge clk) begin : point_check
    point_t got;
    point_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[2*COORD_W+bzs_pkg::IDX_W-1:0]};
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.point_index !== want.point_index) begin
          $display("%0t: point_index expected %0d got %0d", $time, want.point_index,
                   got.point_index);
          error_count++;
        end
        if (got.out_x !== want.out_x) begin
          $display("%0t: out_x expected %h got %h", $time, want.out_x, got.out_x);
          error_count++;
        end
        if (got.out_y !== want.out_y) begin
          $display("%0t: out_y expected %h got %h", $time, want.out_y, got.out_y);
          error_count++;
        end
        if (got.is_last !== want.is_last) begin
          $display("%0t: is_last expected %b got %b", $time, want.is_last, got.is_last);
          error_count++;
        end
      end
    end
  end

  initial begin : sink_pacing
    int run;
    int stall;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic test_coord_extremes();
    curve_t c;
    c = '{split_t: 16'hFFFF, start_x: C_MIN, start_y: C_MIN, ctrl_a_x: C_MAX,
          ctrl_a_y: C_MAX, ctrl_b_x: C_MIN, ctrl_b_y: C_MIN, end_x: C_MAX, end_y: C_MAX};
    send_curve(c, 1'b0);
    c.split_t = 16'h0001;
    send_curve(c, 1'b0);
    c = '{split_t: 16'hFFFF, start_x: C_MAX, start_y: C_MIN, ctrl_a_x: C_MIN,
          ctrl_a_y: C_MAX, ctrl_b_x: C_MAX, ctrl_b_y: C_MIN, end_x: C_MIN, end_y: C_MAX};
    send_curve(c, 1'b0);
    c.split_t = 16'h8000;
    send_curve(c, 1'b0);
    c = '{split_t: 16'h7FFF, start_x: C_MIN, start_y: C_MIN, ctrl_a_x: C_MIN,
          ctrl_a_y: C_MIN, ctrl_b_x: C_MIN, ctrl_b_y: C_MIN, end_x: C_MIN, end_y: C_MIN};
    send_curve(c, 1'b0);
    c = '{split_t: 16'hAAAA, start_x: C_MAX, start_y: C_MAX, ctrl_a_x: C_MAX,
          ctrl_a_y: C_MAX, ctrl_b_x: C_MAX, ctrl_b_y: C_MAX, end_x: C_MAX, end_y: C_MAX};
    send_curve(c, 1'b0);
  endtask

  // t = 0 collapses the left half, half split, the ends of the t range and two interior values
  task automatic test_split_params();
    logic [bzs_pkg::T_IN_W-1:0] ts[6];
    curve_t c;
    ts = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'h5555, 16'h0100};
    foreach (ts[i]) begin
      c = rand_curve();
      c.split_t = ts[i];
      send_curve(c, 1'b0);
    end
  endtask

  task automatic test_degenerate_curves();
    curve_t c;
    coord_t v;
    v = coord_t'($urandom);
    c = '{split_t: 16'h4321, start_x: v, start_y: -v, ctrl_a_x: v, ctrl_a_y: -v,
          ctrl_b_x: v, ctrl_b_y: -v, end_x: v, end_y: -v};
    send_curve(c, 1'b0);
    // collinear, evenly spaced
    c = '{split_t: 16'hC000, start_x: 32'sh0000_0000, start_y: 32'sh0000_0000,
          ctrl_a_x: 32'sh0001_0000, ctrl_a_y: -32'sh0001_0000,
          ctrl_b_x: 32'sh0002_0000, ctrl_b_y: -32'sh0002_0000,
          end_x: 32'sh0003_0000, end_y: -32'sh0003_0000};
    send_curve(c, 1'b0);
    // one-LSB steps exercise rounding toward minus infinity
    c = '{split_t: 16'h0003, start_x: 32'sh0000_0001, start_y: -32'sh0000_0001,
          ctrl_a_x: 32'sh0000_0000, ctrl_a_y: 32'sh0000_0000,
          ctrl_b_x: -32'sh0000_0001, ctrl_b_y: 32'sh0000_0001,
          end_x: 32'sh0000_0002, end_y: -32'sh0000_0002};
    send_curve(c, 1'b0);
  endtask

  task automatic test_random_curves(int count);
    bit no_gaps;
    no_gaps = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = $urandom_range(0, 2) == 0;
      send_curve(rand_curve(), no_gaps);
    end
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_coord_extremes();
    test_split_params();
    test_degenerate_curves();
    test_random_curves(300);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_points.size() != 0) begin
      $display("%0t: %0d words expected, never received", $time, expected_points.size());
      error_count++;
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
